/* rtl/next_fit_block_allocator_top_macros.svh */
// Assertion shorthands used by the block's top-level RTL file.
`ifndef NEXT_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define NEXT_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// Condition that holds at every clock edge out of reset.
`define NFBA_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Condition that, once seen, forces another one on the following edge.
`define NFBA_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

/* rtl/nfba_pkg.sv */
package nfba_pkg;

   localparam int MaxEntries = 128;
   localparam int OwnerBits  = 8;
   localparam int SizeBits   = 16;
   localparam int IdxBits    = $clog2(MaxEntries);
   localparam int CntBits    = IdxBits + 1;

   localparam logic [SizeBits-1:0] ResetTotal = SizeBits'(10240);
   localparam logic [CntBits-1:0]  FullLimit  = CntBits'(MaxEntries - 1);

   typedef enum logic [1:0] {
      KIND_INIT  = 2'd0,
      KIND_ALLOC = 2'd1,
      KIND_FREE  = 2'd2,
      KIND_MERGE = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_SIZE  = 3'd1,
      ST_HOLDS     = 3'd2,
      ST_FULL      = 3'd3,
      ST_NO_FIT    = 3'd4,
      ST_NOT_FOUND = 3'd5
   } status_type;

   typedef struct packed {
      logic [SizeBits-1:0]  size;
      logic                 free;
      logic [OwnerBits-1:0] owner;
   } entry_type;

   typedef struct packed {
      logic                owner_hit;
      logic                fits;
      logic                exact;
      logic [SizeBits-1:0] rest;
      logic [SizeBits-1:0] merged;
   } alu_res_type;

endpackage

/* rtl/nfba_if.sv */
interface nfba_req_if import nfba_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           kind;
   logic [OwnerBits-1:0] owner_id;
   logic [SizeBits-1:0]  request_size;

   modport source (output valid, kind, owner_id, request_size, input ready);
   modport sink   (input valid, kind, owner_id, request_size, output ready);
endinterface

interface nfba_rsp_if import nfba_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic [IdxBits-1:0] block_index;
   logic [IdxBits-1:0] search_start;
   logic [CntBits-1:0] blocks_in_use;

   modport source (output valid, status, block_index, search_start, blocks_in_use,
                   input ready);
   modport sink   (input valid, status, block_index, search_start, blocks_in_use,
                   output ready);
endinterface

interface nfba_csr_if import nfba_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SizeBits-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

/* rtl/nfba_ram.sv */
module nfba_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* rtl/nfba_alu.sv */
module nfba_alu import nfba_pkg::*; (
   input  entry_type            rd_entry,
   input  entry_type            held,
   input  logic [SizeBits-1:0]  need,
   input  logic [OwnerBits-1:0] owner,
   output alu_res_type          res
);

   logic [SizeBits:0] sum;

   always_comb begin
      sum           = {1'b0, rd_entry.size} + {1'b0, held.size};
      res.owner_hit = !rd_entry.free && (rd_entry.owner == owner);
      res.fits      = rd_entry.free && (rd_entry.size >= need);
      res.exact     = (rd_entry.size == need);
      res.rest      = held.size - need;
      // saturate a merged size that overflows the field
      res.merged    = sum[SizeBits] ? {SizeBits{1'b1}} : sum[SizeBits-1:0];
   end

endmodule

/* rtl/next_fit_block_allocator_top.sv */
// Channel  | Dir | Beat contents
// ---------+-----+------------------------------------------------------------
// req_ch   | in  | kind, owner_id, request_size
// rsp_ch   | out | status, block_index, search_start, blocks_in_use
// csr_ch   | in  | total_size (always ready)
//
// One command in flight; req_ch.ready is low until its result is registered.
// The block table has one write port and one registered read port; each entry visited is read, then checked.
// Allocate: check the size, scan for the owner, search for a fit from the pointer, shift entries, split.
// Coalesce: examine each adjacent pair; merge two free blocks and shift the later entries down.
// After reset the S_CLR state writes the initial free block into entry 0.
// The result register lets the next command start while a result waits.
module next_fit_block_allocator_top import nfba_pkg::*; (
   input logic        clock,
   input logic        reset,
   nfba_req_if.sink   req_ch,
   nfba_rsp_if.source rsp_ch,
   nfba_csr_if.sink   csr_ch
);

`include "next_fit_block_allocator_top_macros.svh"

   typedef enum logic [4:0] {
      S_CLR, S_IDLE, S_INIT, S_ACHK,
      S_OWN_RD, S_OWN_CHK,
      S_FIT_RD, S_FIT_CHK,
      S_SH_RD, S_SH_WR, S_SPLIT_A, S_SPLIT_B,
      S_CO_RDA, S_CO_RDB, S_CO_CHK, S_CO_SH_RD, S_CO_SH_WR,
      S_RESP
   } state_type;

   state_type            state_ff, state_in;
   logic [CntBits-1:0]   count_ff, count_in;
   logic [IdxBits-1:0]   ptr_ff, ptr_in;
   logic [SizeBits-1:0]  total_ff, total_in;
   logic [CntBits-1:0]   idx_ff, idx_in;
   logic [CntBits-1:0]   jdx_ff, jdx_in;
   logic [IdxBits-1:0]   at_ff, at_in;
   logic                 phase_ff, phase_in;
   kind_type             kind_ff, kind_in;
   logic [OwnerBits-1:0] owner_ff, owner_in;
   logic [SizeBits-1:0]  need_ff, need_in;
   entry_type            cur_ff, cur_in;
   status_type           status_ff, status_in;
   logic [IdxBits-1:0]   bidx_ff, bidx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           rsp_status_ff, rsp_status_in;
   logic [IdxBits-1:0]   rsp_bidx_ff, rsp_bidx_in;
   logic [IdxBits-1:0]   rsp_ptr_ff, rsp_ptr_in;
   logic [CntBits-1:0]   rsp_count_ff, rsp_count_in;

   logic                 wr_en;
   logic [IdxBits-1:0]   wr_addr;
   entry_type            wr_data;
   logic [IdxBits-1:0]   rd_addr;
   entry_type            rd_data;
   alu_res_type          alu;

   logic [CntBits-1:0]   idx_nx;
   logic [CntBits-1:0]   at_nx;

   nfba_ram #(.Width($bits(entry_type)), .Depth(MaxEntries)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   nfba_alu u_alu (
      .rd_entry (rd_data),
      .held     (cur_ff),
      .need     (need_ff),
      .owner    (owner_ff),
      .res      (alu)
   );

   assign idx_nx = idx_ff + CntBits'(1);
   assign at_nx  = {1'b0, at_ff} + CntBits'(1);

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.block_index   = rsp_bidx_ff;
   assign rsp_ch.search_start  = rsp_ptr_ff;
   assign rsp_ch.blocks_in_use = rsp_count_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      total_in     = total_ff;
      idx_in       = idx_ff;
      jdx_in       = jdx_ff;
      at_in        = at_ff;
      phase_in     = phase_ff;
      kind_in      = kind_ff;
      owner_in     = owner_ff;
      need_in      = need_ff;
      cur_in       = cur_ff;
      status_in    = status_ff;
      bidx_in      = bidx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_bidx_in  = rsp_bidx_ff;
      rsp_ptr_in   = rsp_ptr_ff;
      rsp_count_in = rsp_count_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_addr      = '0;

      if (csr_ch.valid) begin
         total_in = csr_ch.data;
      end
      // drop the result once the sink takes the beat
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLR: begin
            wr_en    = 1'b1;
            wr_data  = '{size: ResetTotal, free: 1'b1, owner: '0};
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               kind_in   = kind_type'(req_ch.kind);
               owner_in  = req_ch.owner_id;
               need_in   = req_ch.request_size;
               status_in = ST_OK;
               bidx_in   = '0;
               idx_in    = '0;
               case (kind_type'(req_ch.kind))
                  KIND_INIT:  state_in = S_INIT;
                  KIND_ALLOC: state_in = S_ACHK;
                  KIND_FREE:  state_in = S_OWN_RD;
                  KIND_MERGE: state_in = S_CO_RDA;
                  default:    state_in = S_RESP;
               endcase
            end
         end
         S_INIT: begin
            wr_en    = 1'b1;
            wr_data  = '{size: total_ff, free: 1'b1, owner: '0};
            count_in = CntBits'(1);
            ptr_in   = '0;
            state_in = S_RESP;
         end
         S_ACHK: begin
            if (need_ff == '0 || need_ff > total_ff) begin
               status_in = ST_BAD_SIZE;
               state_in  = S_RESP;
            end else begin
               state_in = S_OWN_RD;
            end
         end
         S_OWN_RD: begin
            if (idx_ff >= count_ff) begin
               if (kind_ff == KIND_FREE) begin
                  status_in = ST_NOT_FOUND;
                  state_in  = S_RESP;
               end else if (count_ff >= FullLimit) begin
                  status_in = ST_FULL;
                  state_in  = S_RESP;
               end else begin
                  idx_in   = {1'b0, ptr_ff};
                  phase_in = 1'b0;
                  state_in = S_FIT_RD;
               end
            end else begin
               rd_addr  = idx_ff[IdxBits-1:0];
               state_in = S_OWN_CHK;
            end
         end
         S_OWN_CHK: begin
            if (alu.owner_hit) begin
               if (kind_ff == KIND_FREE) begin
                  wr_en   = 1'b1;
                  wr_addr = idx_ff[IdxBits-1:0];
                  wr_data = '{size: rd_data.size, free: 1'b1, owner: '0};
                  bidx_in = idx_ff[IdxBits-1:0];
               end else begin
                  status_in = ST_HOLDS;
               end
               state_in = S_RESP;
            end else begin
               idx_in   = idx_nx;
               state_in = S_OWN_RD;
            end
         end
         S_FIT_RD: begin
            rd_addr  = idx_ff[IdxBits-1:0];
            state_in = S_FIT_CHK;
         end
         S_FIT_CHK: begin
            if (alu.fits) begin
               at_in   = idx_ff[IdxBits-1:0];
               cur_in  = rd_data;
               bidx_in = idx_ff[IdxBits-1:0];
               if (alu.exact) begin
                  wr_en     = 1'b1;
                  wr_addr   = idx_ff[IdxBits-1:0];
                  wr_data   = '{size: rd_data.size, free: 1'b0, owner: owner_ff};
                  ptr_in    = (idx_nx == count_ff) ? '0 : idx_nx[IdxBits-1:0];
                  state_in  = S_RESP;
               end else begin
                  jdx_in   = count_ff;
                  state_in = S_SH_RD;
               end
            end else if (!phase_ff) begin
               if (idx_nx == count_ff) begin
                  if (ptr_ff == '0) begin
                     status_in = ST_NO_FIT;
                     state_in  = S_RESP;
                  end else begin
                     idx_in   = '0;
                     phase_in = 1'b1;
                     state_in = S_FIT_RD;
                  end
               end else begin
                  idx_in   = idx_nx;
                  state_in = S_FIT_RD;
               end
            end else if (idx_nx == {1'b0, ptr_ff}) begin
               status_in = ST_NO_FIT;
               state_in  = S_RESP;
            end else begin
               idx_in   = idx_nx;
               state_in = S_FIT_RD;
            end
         end
         // open a slot after the chosen block, top entry first
         S_SH_RD: begin
            if (jdx_ff > at_nx) begin
               rd_addr  = jdx_ff[IdxBits-1:0] - IdxBits'(1);
               state_in = S_SH_WR;
            end else begin
               state_in = S_SPLIT_A;
            end
         end
         S_SH_WR: begin
            wr_en    = 1'b1;
            wr_addr  = jdx_ff[IdxBits-1:0];
            wr_data  = rd_data;
            jdx_in   = jdx_ff - CntBits'(1);
            state_in = S_SH_RD;
         end
         S_SPLIT_A: begin
            wr_en    = 1'b1;
            wr_addr  = at_ff;
            wr_data  = '{size: need_ff, free: 1'b0, owner: owner_ff};
            state_in = S_SPLIT_B;
         end
         S_SPLIT_B: begin
            wr_en    = 1'b1;
            wr_addr  = at_nx[IdxBits-1:0];
            wr_data  = '{size: alu.rest, free: 1'b1, owner: '0};
            count_in = count_ff + CntBits'(1);
            ptr_in   = (at_nx == count_ff + CntBits'(1)) ? '0 : at_nx[IdxBits-1:0];
            state_in = S_RESP;
         end
         S_CO_RDA: begin
            if (idx_nx >= count_ff) begin
               state_in = S_RESP;
            end else begin
               rd_addr  = idx_ff[IdxBits-1:0];
               state_in = S_CO_RDB;
            end
         end
         S_CO_RDB: begin
            rd_addr  = idx_nx[IdxBits-1:0];
            cur_in   = rd_data;
            state_in = S_CO_CHK;
         end
         S_CO_CHK: begin
            if (cur_ff.free && rd_data.free) begin
               wr_en    = 1'b1;
               wr_addr  = idx_ff[IdxBits-1:0];
               wr_data  = '{size: alu.merged, free: 1'b1, owner: cur_ff.owner};
               jdx_in   = idx_nx;
               state_in = S_CO_SH_RD;
            end else begin
               idx_in   = idx_nx;
               state_in = S_CO_RDA;
            end
         end
         // close the gap left by the absorbed block
         S_CO_SH_RD: begin
            if (jdx_ff + CntBits'(1) < count_ff) begin
               rd_addr  = jdx_ff[IdxBits-1:0] + IdxBits'(1);
               state_in = S_CO_SH_WR;
            end else begin
               count_in = count_ff - CntBits'(1);
               // pointer can only sit on the removed top slot; wrap it
               if ({1'b0, ptr_ff} >= count_ff - CntBits'(1)) begin
                  ptr_in = '0;
               end
               state_in = S_CO_RDA;
            end
         end
         S_CO_SH_WR: begin
            wr_en    = 1'b1;
            wr_addr  = jdx_ff[IdxBits-1:0];
            wr_data  = rd_data;
            jdx_in   = jdx_ff + CntBits'(1);
            state_in = S_CO_SH_RD;
         end
         S_RESP: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_bidx_in   = bidx_ff;
               rsp_ptr_in    = ptr_ff;
               rsp_count_in  = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         count_ff     <= CntBits'(1);
         ptr_ff       <= '0;
         total_ff     <= ResetTotal;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      jdx_ff        <= jdx_in;
      at_ff         <= at_in;
      phase_ff      <= phase_in;
      kind_ff       <= kind_in;
      owner_ff      <= owner_in;
      need_ff       <= need_in;
      cur_ff        <= cur_in;
      status_ff     <= status_in;
      bidx_ff       <= bidx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bidx_ff   <= rsp_bidx_in;
      rsp_ptr_ff    <= rsp_ptr_in;
      rsp_count_ff  <= rsp_count_in;
   end

   `NFBA_ASSERT_ALWAYS(a_count_range, count_ff != '0 && count_ff <= CntBits'(MaxEntries), "block count out of range")
   `NFBA_ASSERT_ALWAYS(a_ptr_in_table, {1'b0, ptr_ff} < count_ff, "search pointer beyond table")
   `NFBA_ASSERT_ALWAYS(a_split_room, state_ff != S_SPLIT_B || count_ff < FullLimit, "split on full table")
   `NFBA_ASSERT_NEXT(a_busy_after_accept, req_ch.valid && req_ch.ready, !req_ch.ready, "second command taken while busy")

endmodule
